// ===== sv/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int MaxResults = 4;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_CLOSED   = 3'd1,
        KIND_BAD_HEX  = 3'd2,
        KIND_BAD_SURR = 3'd3,
        KIND_UNTERM   = 3'd4
    } kind_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0c;
    localparam logic [7:0] BYTE_LF = 8'h0a;
    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_HT = 8'h09;

    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    // One accepted byte worth of results; slot 0 goes out first.
    typedef struct packed {
        logic [2:0]            cnt;
        logic [3:0][2:0]       kind;
        logic [3:0][7:0]       data;
    } cmd_t;

    // {not_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic cmd_t utf8_encode(input logic [20:0] cp);
        cmd_t cmd;
        cmd = '0;
        for (int i = 0; i < MaxResults; i++) begin
            cmd.kind[i] = KIND_DATA;
        end
        if (cp < 21'h80) begin
            cmd.cnt     = 3'd1;
            cmd.data[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h800) begin
            cmd.cnt     = 3'd2;
            cmd.data[0] = {3'b110, cp[10:6]};
            cmd.data[1] = {2'b10, cp[5:0]};
        end
        else if (cp < SUPP_BASE) begin
            cmd.cnt     = 3'd3;
            cmd.data[0] = {4'b1110, cp[15:12]};
            cmd.data[1] = {2'b10, cp[11:6]};
            cmd.data[2] = {2'b10, cp[5:0]};
        end
        else begin
            cmd.cnt     = 3'd4;
            cmd.data[0] = {5'b11110, cp[20:18]};
            cmd.data[1] = {2'b10, cp[17:12]};
            cmd.data[2] = {2'b10, cp[11:6]};
            cmd.data[3] = {2'b10, cp[5:0]};
        end
        return cmd;
    endfunction

endpackage

// ===== sv/jsu_front.sv =====
`timescale 1ns / 1ps

module jsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    output logic               push,
    output jsu_pkg::cmd_t      cmd
);
    import jsu_pkg::*;

    typedef enum logic [5:0] {
        M_PLAIN   = 6'b000001,
        M_ESC     = 6'b000010,
        M_HEX1    = 6'b000100,
        M_WANT_BS = 6'b001000,
        M_WANT_U  = 6'b010000,
        M_HEX2    = 6'b100000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] unit1_reg, unit1_next;
    logic [15:0] unit2_reg, unit2_next;
    logic [1:0]  digits_reg, digits_next;
    logic [4:0]  hex;
    logic        not_hex;
    logic [3:0]  hex_val;

    assign hex     = hex_decode(in_byte);
    assign not_hex = hex[4];
    assign hex_val = hex[3:0];

    always_comb
    begin
        mode_next   = mode_reg;
        unit1_next  = unit1_reg;
        unit2_next  = unit2_reg;
        digits_next = digits_reg;
        cmd         = '0;
        unique case (mode_reg)
            M_ESC:
            begin
                mode_next = M_PLAIN;
                cmd.cnt   = 3'd1;
                case (in_byte) inside
                    CH_BSLASH, CH_SLASH, CH_QUOTE: cmd.data[0] = in_byte;
                    CH_B: cmd.data[0] = BYTE_BS;
                    CH_F: cmd.data[0] = BYTE_FF;
                    CH_N: cmd.data[0] = BYTE_LF;
                    CH_R: cmd.data[0] = BYTE_CR;
                    CH_T: cmd.data[0] = BYTE_HT;
                    CH_U:
                    begin
                        cmd.cnt     = 3'd0;
                        mode_next   = M_HEX1;
                        digits_next = 2'd0;
                    end
                    default:
                    begin
                        // unknown escape: backslash, then the byte as plain text
                        cmd.cnt     = 3'd2;
                        cmd.data[0] = CH_BSLASH;
                        if (in_byte == CH_NUL) begin
                            cmd.kind[1] = KIND_UNTERM;
                        end
                        else if (in_byte == CH_QUOTE) begin
                            cmd.kind[1] = KIND_CLOSED;
                        end
                        else begin
                            cmd.data[1] = in_byte;
                        end
                    end
                endcase
            end
            M_HEX1:
            begin
                if (not_hex) begin
                    cmd.cnt     = 3'd1;
                    cmd.kind[0] = KIND_BAD_HEX;
                    mode_next   = M_PLAIN;
                end
                else begin
                    unit1_next = {unit1_reg[11:0], hex_val};
                    if (digits_reg != 2'd3) begin
                        digits_next = digits_reg + 2'd1;
                    end
                    else if (unit1_next[15:10] == HIGH_SURR_TAG) begin
                        mode_next = M_WANT_BS;
                    end
                    else begin
                        cmd       = utf8_encode({5'd0, unit1_next});
                        mode_next = M_PLAIN;
                    end
                end
            end
            M_WANT_BS:
            begin
                if (in_byte == CH_BSLASH) begin
                    mode_next = M_WANT_U;
                end
                else begin
                    cmd.cnt     = 3'd1;
                    cmd.kind[0] = KIND_BAD_SURR;
                    mode_next   = M_PLAIN;
                end
            end
            M_WANT_U:
            begin
                if (in_byte == CH_U) begin
                    mode_next   = M_HEX2;
                    digits_next = 2'd0;
                end
                else begin
                    cmd.cnt     = 3'd1;
                    cmd.kind[0] = KIND_BAD_SURR;
                    mode_next   = M_PLAIN;
                end
            end
            M_HEX2:
            begin
                if (not_hex) begin
                    cmd.cnt     = 3'd1;
                    cmd.kind[0] = KIND_BAD_SURR;
                    mode_next   = M_PLAIN;
                end
                else begin
                    unit2_next = {unit2_reg[11:0], hex_val};
                    if (digits_reg != 2'd3) begin
                        digits_next = digits_reg + 2'd1;
                    end
                    else begin
                        mode_next = M_PLAIN;
                        if (unit2_next[15:10] != LOW_SURR_TAG) begin
                            cmd.cnt     = 3'd1;
                            cmd.kind[0] = KIND_BAD_SURR;
                        end
                        else begin
                            cmd = utf8_encode(SUPP_BASE +
                                              {1'b0, unit1_reg[9:0], unit2_next[9:0]});
                        end
                    end
                end
            end
            default:
            begin
                mode_next = M_PLAIN;
                if (in_byte == CH_NUL) begin
                    cmd.cnt     = 3'd1;
                    cmd.kind[0] = KIND_UNTERM;
                end
                else if (in_byte == CH_QUOTE) begin
                    cmd.cnt     = 3'd1;
                    cmd.kind[0] = KIND_CLOSED;
                end
                else if (in_byte == CH_BSLASH) begin
                    mode_next = M_ESC;
                end
                else begin
                    cmd.cnt     = 3'd1;
                    cmd.data[0] = in_byte;
                end
            end
        endcase
    end

    assign push = accept && (cmd.cnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_PLAIN;
            digits_reg <= 2'd0;
        end
        else if (accept) begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            unit1_reg <= unit1_next;
            unit2_reg <= unit2_next;
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
`timescale 1ns / 1ps

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsu_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output jsu_pkg::cmd_t      head_cmd,
    output logic               empty,
    output logic               full
);
    import jsu_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign empty    = (count_reg == CW'(0));
    assign full     = (count_reg == CW'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
`timescale 1ns / 1ps

module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  jsu_pkg::cmd_t      head_cmd,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         out_kind,
    output logic [7:0]         out_byte,
    output logic               out_last
);
    import jsu_pkg::*;

    logic [1:0] slot_reg;
    logic       valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       emit;
    logic       is_last;

    assign emit    = !empty && (!valid_reg || !out_stall);
    assign is_last = ({1'b0, slot_reg} + 3'd1) == head_cmd.cnt;
    assign pop     = emit && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            slot_reg  <= 2'd0;
        end
        else begin
            if (emit) begin
                valid_reg <= 1'b1;
                slot_reg  <= is_last ? 2'd0 : slot_reg + 2'd1;
            end
            else if (!out_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            kind_reg <= head_cmd.kind[slot_reg];
            byte_reg <= head_cmd.data[slot_reg];
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// An input byte's results pass through the queue and the output register to the outputs.
// Throughput: one input byte per cycle while the queue has room; one result per cycle out
// while out_stall is low. A \u escape that completes emits up to 4 bytes, one result each.
// The QUEUE_DEPTH-entry queue between decoder and emitter absorbs those bursts.
// Reset (rst_n, async, active low) empties the queue and returns to plain text mode.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte,
    output logic       out_last
);
    import jsu_pkg::*;

    logic  accept;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;
    cmd_t  push_cmd;
    cmd_t  head_cmd;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    jsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push),
        .cmd     (push_cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty),
        .full     (full)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    a_report_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != KIND_DATA) |-> out_last && (out_byte == 8'd0))
        else $error("status result not last or carries a byte");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind <= KIND_UNTERM))
        else $error("result kind out of range");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (head_cmd.cnt != 3'd0) && (head_cmd.cnt <= 3'(MaxResults)))
        else $error("queued entry has bad result count");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

endmodule

// ===== test/unescape_checker.sv =====
`timescale 1ns / 1ps

module unescape_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] out_kind,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    output int         errors,
    output int         pending
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX1,
        MODE_WANT_BS,
        MODE_WANT_U,
        MODE_HEX2
    } decode_mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } utf8_result_t;

    utf8_result_t expected_q[$];
    decode_mode_t mode;
    logic [15:0]  hi_unit;
    logic [15:0]  lo_unit;
    logic [1:0]   digit_cnt;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c) - 'h30;
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return int'(c) - 'h61 + 10;
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return int'(c) - 'h41 + 10;
        end
        return -1;
    endfunction

    task automatic clear_decoder();
        mode      = MODE_PLAIN;
        hi_unit   = '0;
        lo_unit   = '0;
        digit_cnt = '0;
    endtask

    task automatic emit(input kind_t k, input logic [7:0] b);
        utf8_result_t r;
        r.kind = k;
        r.data = (k == KIND_DATA) ? b : 8'h00;
        r.last = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic flag(input kind_t k);
        clear_decoder();
        emit(k, 8'h00);
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit(KIND_DATA, cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            emit(KIND_DATA, 8'hc0 | 8'(cp >> 6));
            emit(KIND_DATA, 8'h80 | 8'(cp & 21'h3f));
        end
        else if (cp < 21'h10000)
        begin
            emit(KIND_DATA, 8'he0 | 8'(cp >> 12));
            emit(KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3f));
            emit(KIND_DATA, 8'h80 | 8'(cp & 21'h3f));
        end
        else
        begin
            emit(KIND_DATA, 8'hf0 | 8'((cp >> 18) & 21'h07));
            emit(KIND_DATA, 8'h80 | 8'((cp >> 12) & 21'h3f));
            emit(KIND_DATA, 8'h80 | 8'((cp >> 6) & 21'h3f));
            emit(KIND_DATA, 8'h80 | 8'(cp & 21'h3f));
        end
        clear_decoder();
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == CH_NUL)
        begin
            flag(KIND_UNTERM);
        end
        else if (c == CH_QUOTE)
        begin
            flag(KIND_CLOSED);
        end
        else if (c == CH_BSLASH)
        begin
            mode = MODE_ESC;
        end
        else
        begin
            mode = MODE_PLAIN;
            emit(KIND_DATA, c);
        end
    endtask

    task automatic decode_byte(input logic [7:0] c);
        int           nib;
        int           prior_cnt;
        logic [20:0]  cp;
        utf8_result_t tail;
        prior_cnt = expected_q.size();
        nib       = nibble_of(c);
        case (mode)
            MODE_ESC:
            begin
                mode = MODE_PLAIN;
                case (c)
                    CH_BSLASH, CH_SLASH, CH_QUOTE: emit(KIND_DATA, c);
                    CH_B: emit(KIND_DATA, BYTE_BS);
                    CH_F: emit(KIND_DATA, BYTE_FF);
                    CH_N: emit(KIND_DATA, BYTE_LF);
                    CH_R: emit(KIND_DATA, BYTE_CR);
                    CH_T: emit(KIND_DATA, BYTE_HT);
                    CH_U:
                    begin
                        mode      = MODE_HEX1;
                        hi_unit   = '0;
                        digit_cnt = '0;
                    end
                    default:
                    begin
                        emit(KIND_DATA, CH_BSLASH);
                        take_plain(c);
                    end
                endcase
            end
            MODE_HEX1:
            begin
                if (nib < 0)
                begin
                    flag(KIND_BAD_HEX);
                end
                else
                begin
                    hi_unit = {hi_unit[11:0], nib[3:0]};
                    if (digit_cnt < 2'd3)
                    begin
                        digit_cnt++;
                    end
                    else
                    begin
                        digit_cnt = '0;
                        if ((hi_unit & 16'hfc00) == 16'hd800)
                        begin
                            mode = MODE_WANT_BS;
                        end
                        else
                        begin
                            emit_utf8({5'b0, hi_unit});
                        end
                    end
                end
            end
            MODE_WANT_BS:
            begin
                if (c == CH_BSLASH)
                begin
                    mode = MODE_WANT_U;
                end
                else
                begin
                    flag(KIND_BAD_SURR);
                end
            end
            MODE_WANT_U:
            begin
                if (c == CH_U)
                begin
                    mode      = MODE_HEX2;
                    lo_unit   = '0;
                    digit_cnt = '0;
                end
                else
                begin
                    flag(KIND_BAD_SURR);
                end
            end
            MODE_HEX2:
            begin
                if (nib < 0)
                begin
                    flag(KIND_BAD_SURR);
                end
                else
                begin
                    lo_unit = {lo_unit[11:0], nib[3:0]};
                    if (digit_cnt < 2'd3)
                    begin
                        digit_cnt++;
                    end
                    else
                    begin
                        digit_cnt = '0;
                        if ((lo_unit & 16'hfc00) != 16'hdc00)
                        begin
                            flag(KIND_BAD_SURR);
                        end
                        else
                        begin
                            cp = 21'h10000 + ({5'b0, hi_unit - 16'hd800} << 10)
                                 + {5'b0, lo_unit - 16'hdc00};
                            emit_utf8(cp);
                        end
                    end
                end
            end
            default: take_plain(c);
        endcase
        if (expected_q.size() > prior_cnt)
        begin
            tail      = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utf8_result_t want;
        if (!rst_n)
        begin
            clear_decoder();
            expected_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer kind=%0d byte=%02h last=%0d",
                             $time, out_kind, out_byte, out_last);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_kind !== want.kind)
                    begin
                        $display("%0t: out_kind expected %0d got %0d",
                                 $time, want.kind, out_kind);
                        errors++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.data, out_byte);
                        errors++;
                    end
                    if (out_last !== want.last)
                    begin
                        $display("%0t: out_last expected %0d got %0d",
                                 $time, want.last, out_last);
                        errors++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import jsu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic       in_took;
    int         errors;
    int         pending;
    int         sent;
    int         burst_left;

    json_string_unescape_utf8 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    unescape_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("json_string_unescape_utf8 regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        in_took <= in_valid && !in_stall;
    end

    // receiver stall pattern
    initial
    begin
        int r;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(15, 40)) @(negedge clk);
            end
        end
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
            || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (is_hex(b))
        begin
            b = "g";
        end
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send(input logic [7:0] b);
        int gap;
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                burst_left = $urandom_range(16, 48);
                gap        = 0;
            end
            else if (r < 55)
            begin
                gap = 0;
            end
            else if (r < 85)
            begin
                gap = $urandom_range(1, 3);
            end
            else if (r < 97)
            begin
                gap = $urandom_range(4, 10);
            end
            else
            begin
                gap = $urandom_range(20, 40);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(negedge clk);
        while (!in_took) @(negedge clk);
        sent++;
    endtask

    task automatic send_escape(input logic [7:0] c);
        send(CH_BSLASH);
        send(c);
    endtask

    task automatic send_unit(input logic [15:0] u);
        send_escape(CH_U);
        for (int i = 3; i >= 0; i--)
        begin
            send(hex_char(u[i*4 +: 4]));
        end
    endtask

    task automatic send_high();
        send_unit(16'hd800 | 16'($urandom_range(0, 1023)));
    endtask

    // high surrogate followed by something that cannot complete the pair
    task automatic send_broken_pair();
        logic [7:0]  b;
        logic [15:0] u;
        send_high();
        case ($urandom_range(0, 4))
            0:
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_BSLASH)
                begin
                    b = "q";
                end
                send(b);
            end
            1:
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_U)
                begin
                    b = "v";
                end
                send_escape(b);
            end
            2:
            begin
                send_escape(CH_U);
                repeat ($urandom_range(0, 3)) send(hex_char(4'($urandom_range(0, 15))));
                send(non_hex());
            end
            3:
            begin
                u = 16'($urandom);
                if ((u & 16'hfc00) == 16'hdc00)
                begin
                    u ^= 16'h0400;
                end
                send_unit(u);
            end
            default: send(CH_NUL);
        endcase
    endtask

    initial
    begin
        logic [7:0]  esc_set[8];
        logic [15:0] u;
        int          target;
        int          r;
        esc_set  = '{CH_BSLASH, CH_SLASH, CH_QUOTE, CH_B, CH_F, CH_N, CH_R, CH_T};
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        sent       = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send("A");
        send(8'hff);
        send(8'h01);
        send(CH_QUOTE);
        send(CH_NUL);
        foreach (esc_set[i])
        begin
            send_escape(esc_set[i]);
        end
        send_escape("x");
        send_escape(CH_NUL);
        send_unit(16'h0000);
        send_unit(16'h07ff);
        send_unit(16'hffff);
        send_unit(16'hdc00);
        send_unit(16'hd83d);
        send_unit(16'hde00);
        send_unit(16'hdbff);
        send_unit(16'hdfff);
        send_escape(CH_U);
        send("1");
        send("g");
        send_unit(16'hd800);
        send("a");
        send_unit(16'hd800);
        send_unit(16'h0041);
        send_unit(16'hd800);
        send(CH_NUL);

        target = 280;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                u[7:0] = 8'($urandom_range(1, 255));
                if (u[7:0] == CH_QUOTE || u[7:0] == CH_BSLASH)
                begin
                    u[7:0] = "z";
                end
                send(u[7:0]);
            end
            else if (r < 40)
            begin
                send_escape(esc_set[$urandom_range(0, 7)]);
            end
            else if (r < 45)
            begin
                send_escape(8'($urandom_range(0, 255)));
            end
            else if (r < 60)
            begin
                case ($urandom_range(0, 2))
                    0: u = 16'($urandom_range(0, 'h7f));
                    1: u = 16'($urandom_range('h80, 'h7ff));
                    default: u = 16'($urandom_range('h800, 'hffff));
                endcase
                if ((u & 16'hfc00) == 16'hd800)
                begin
                    u ^= 16'h0400;
                end
                send_unit(u);
            end
            else if (r < 72)
            begin
                send_high();
                send_unit(16'hdc00 | 16'($urandom_range(0, 1023)));
            end
            else if (r < 80)
            begin
                send_escape(CH_U);
                repeat ($urandom_range(0, 3)) send(hex_char(4'($urandom_range(0, 15))));
                send(non_hex());
            end
            else if (r < 88)
            begin
                send_broken_pair();
            end
            else if (r < 93)
            begin
                send(CH_QUOTE);
            end
            else if (r < 96)
            begin
                send(CH_NUL);
            end
            else
            begin
                send(8'($urandom_range(0, 255)));
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
        begin
            $display("json_string_unescape_utf8 regression: pass");
        end
        else
        begin
            $display("json_string_unescape_utf8 regression: fail");
        end
        $finish;
    end

endmodule
